[hw/rtl/aes_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes_pkg: shared types and constants of the audio event scorer
// Register codes, reset values, queue item layout and back-end states.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int ScoreW = 9;
	localparam int DiffW  = 17;
	localparam int GainW  = 16;

	localparam logic [ScoreW-1:0] SCORE_ONE = 9'd256;

	// register indexes on the configuration port
	typedef enum logic [2:0] {
		REG_ENERGY_GAIN   = 3'd0,
		REG_ONSET_GAIN    = 3'd1,
		REG_SPECTRAL_GAIN = 3'd2,
		REG_ENERGY_WT     = 3'd3,
		REG_ONSET_WT      = 3'd4,
		REG_SPECTRAL_WT   = 3'd5,
		REG_DAMPING_FLOOR = 3'd6
	} aes_reg_t;

	localparam logic [GainW-1:0]  RST_ENERGY_GAIN   = 16'd256;
	localparam logic [GainW-1:0]  RST_ONSET_GAIN    = 16'd512;
	localparam logic [GainW-1:0]  RST_SPECTRAL_GAIN = 16'd128;
	localparam logic [ScoreW-1:0] RST_ENERGY_WT     = 9'd128;
	localparam logic [ScoreW-1:0] RST_ONSET_WT      = 9'd64;
	localparam logic [ScoreW-1:0] RST_SPECTRAL_WT   = 9'd64;
	localparam logic [ScoreW-1:0] RST_DAMPING_FLOOR = 9'd128;
	localparam logic [15:0]       RST_LAST_ENERGY   = 16'd256;

	typedef struct packed {
		logic [GainW-1:0]  energy_gain;
		logic [GainW-1:0]  onset_gain;
		logic [GainW-1:0]  spectral_gain;
		logic [ScoreW-1:0] energy_wt;
		logic [ScoreW-1:0] onset_wt;
		logic [ScoreW-1:0] spectral_wt;
		logic [ScoreW-1:0] damping_floor;
	} aes_cfg_t;

	// one classified frame waiting for the back end
	typedef struct packed {
		logic signed [DiffW-1:0] ediff;   // energy_dev - 1.0
		logic signed [DiffW-1:0] odiff;   // energy_dev - previous energy_dev
		logic signed [DiffW-1:0] sdiff;   // zcr_dev + hf_dev
		logic [ScoreW-1:0]       conf;    // base_conf saturated to 1.0
	} aes_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} aes_qstat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SUB,
		BK_MIX,
		BK_OUT
	} aes_bk_state_t;

endpackage

`default_nettype wire

[hw/rtl/aes_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes_queue: two-entry request queue
// Decouples the classifying front end from the arithmetic back end.
// ----------------------------------------------------------------------------
module aes_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  aes_pkg::aes_item_t  push_item,
	input  wire                 pop,
	output aes_pkg::aes_item_t  pop_item,
	output aes_pkg::aes_qstat_t qst
);

	aes_pkg::aes_item_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign qst.full  = (count_q == 2'd2);
	assign qst.empty = (count_q == 2'd0);
	assign pop_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_item;
	end

endmodule

`default_nettype wire

[hw/rtl/aes_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes_front: input side of the scorer
// Accepts frames, forms the three signed deviations and tracks the previous
// energy deviation.
// ----------------------------------------------------------------------------
module aes_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	// energy_dev[15:0], zcr_dev[31:16], hf_dev[47:32], base_conf[56:48], zero pad
	input  wire  [63:0]         s_tdata,
	input  aes_pkg::aes_qstat_t qst,
	output logic                push,
	output aes_pkg::aes_item_t  push_item
);

	logic [15:0] last_q;
	logic [15:0] edev;
	logic [15:0] zcr;
	logic [15:0] hf;
	logic [8:0]  conf_raw;

	assign edev     = s_tdata[15:0];
	assign zcr      = s_tdata[31:16];
	assign hf       = s_tdata[47:32];
	assign conf_raw = s_tdata[56:48];

	assign s_tready = !qst.full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		push_item.ediff = $signed({1'b0, edev}) - $signed(17'd256);
		push_item.odiff = $signed({1'b0, edev}) - $signed({1'b0, last_q});
		push_item.sdiff = $signed({zcr[15], zcr}) + $signed({hf[15], hf});
		push_item.conf  = (conf_raw > aes_pkg::SCORE_ONE) ? aes_pkg::SCORE_ONE : conf_raw;
	end

	// onset is taken against the frame accepted just before
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= aes_pkg::RST_LAST_ENERGY;
		end else if (push) begin
			last_q <= edev;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/aes_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes_back: arithmetic sequencer of the scorer
// Sub-scores and damping scale, then weighted mix and agreement, then the
// damped event score into the result register toward the output stream.
// ----------------------------------------------------------------------------
module aes_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  aes_pkg::aes_cfg_t   cfg,
	input  aes_pkg::aes_qstat_t qst,
	input  aes_pkg::aes_item_t  q_item,
	output logic                pop,
	output logic                m_tvalid,
	input  wire                 m_tready,
	// event_score[8:0], event_confidence[17:9], energy_score[26:18],
	// onset_score[35:27], spectral_score[44:36], zero pad
	output logic [47:0]         m_tdata
);

	// (a * gain) >> 8 floored, saturated to 0..1.0
	function automatic logic [8:0] scaled_score(input logic signed [16:0] a,
	                                            input logic [15:0] gain);
		logic signed [33:0] p;
		logic [25:0]        q;
		begin
			p = a * $signed({1'b0, gain});
			q = p[33:8];
			if (p <= 34'sd0)                      scaled_score = 9'd0;
			else if (q > 26'(aes_pkg::SCORE_ONE)) scaled_score = aes_pkg::SCORE_ONE;
			else                                  scaled_score = q[8:0];
		end
	endfunction

	aes_pkg::aes_bk_state_t state_q, state_nx;
	aes_pkg::aes_item_t     item_q;

	logic [8:0]  es_q, os_q, ss_q, scale_q, comb_q, agree_q;
	logic [47:0] m_tdata_q;
	logic        m_tvalid_q;
	logic        ld_sub, ld_mix, ld_out;

	logic [8:0]  fl;
	logic [17:0] scale_prod;
	logic [9:0]  scale_sum;
	logic [17:0] we_prod, wo_prod, ws_prod;
	logic [11:0] wsum;
	logic [8:0]  mx, mn;
	logic [17:0] ev_prod;
	logic [8:0]  ev;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			aes_pkg::BK_IDLE: if (!qst.empty) state_nx = aes_pkg::BK_SUB;
			aes_pkg::BK_SUB:  state_nx = aes_pkg::BK_MIX;
			aes_pkg::BK_MIX:  state_nx = aes_pkg::BK_OUT;
			aes_pkg::BK_OUT:  if (!m_tvalid_q || m_tready) state_nx = aes_pkg::BK_IDLE;
			default:          state_nx = aes_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop    = 1'b0;
		ld_sub = 1'b0;
		ld_mix = 1'b0;
		ld_out = 1'b0;
		case (state_q)
			aes_pkg::BK_IDLE: pop    = !qst.empty;
			aes_pkg::BK_SUB:  ld_sub = 1'b1;
			aes_pkg::BK_MIX:  ld_mix = 1'b1;
			aes_pkg::BK_OUT:  ld_out = !m_tvalid_q || m_tready;
			default:          pop    = 1'b0;
		endcase
	end

	// damping scale = floor + (1 - floor) * conf
	always_comb begin
		fl         = (cfg.damping_floor > aes_pkg::SCORE_ONE) ? aes_pkg::SCORE_ONE
		                                                      : cfg.damping_floor;
		scale_prod = (aes_pkg::SCORE_ONE - fl) * item_q.conf;
		scale_sum  = {1'b0, fl} + scale_prod[17:8];
	end

	always_comb begin
		we_prod = cfg.energy_wt   * es_q;
		wo_prod = cfg.onset_wt    * os_q;
		ws_prod = cfg.spectral_wt * ss_q;
		wsum    = {2'b00, we_prod[17:8]} + {2'b00, wo_prod[17:8]} + {2'b00, ws_prod[17:8]};
		mx = es_q;
		mn = es_q;
		if (os_q > mx) mx = os_q;
		if (ss_q > mx) mx = ss_q;
		if (os_q < mn) mn = os_q;
		if (ss_q < mn) mn = ss_q;
	end

	always_comb begin
		ev_prod = comb_q * scale_q;
		ev      = (ev_prod[17:8] > 10'(aes_pkg::SCORE_ONE)) ? aes_pkg::SCORE_ONE
		                                                    : ev_prod[16:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= aes_pkg::BK_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ld_out)        m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) item_q <= q_item;
		if (ld_sub) begin
			es_q    <= scaled_score(item_q.ediff, cfg.energy_gain);
			os_q    <= scaled_score(item_q.odiff, cfg.onset_gain);
			ss_q    <= scaled_score(item_q.sdiff, cfg.spectral_gain);
			scale_q <= scale_sum[8:0];
		end
		if (ld_mix) begin
			comb_q  <= (wsum > 12'(aes_pkg::SCORE_ONE)) ? aes_pkg::SCORE_ONE : wsum[8:0];
			agree_q <= aes_pkg::SCORE_ONE - (mx - mn);
		end
		if (ld_out) m_tdata_q <= {3'b000, ss_q, os_q, es_q, agree_q, ev};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

[hw/rtl/audio_event_scorer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted frame passes the queue, item, sub-score, mix and result registers to m_tvalid.
// Frames: taken from the queue one at a time by the back-end sequencer that
//   walks sub-scores, weighted mix and damping through its multipliers.
// Reset (arst_n low, asynchronous): registers take their default values, the
//   previous energy deviation returns to 1.0, queue and output are emptied.
// ----------------------------------------------------------------------------
// audio_event_scorer_unit: audio feature frame event scorer
// Front end classifies frames into deviations, a two-entry queue hands them to
// a sequenced back end that produces the scores.
// ----------------------------------------------------------------------------
module audio_event_scorer_unit (
	input  wire         clk,
	input  wire         arst_n,
	// configuration write port, no read-back
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [15:0] cfg_data,
	// input frames
	input  wire         s_tvalid,
	output logic        s_tready,
	// energy_dev[15:0], zcr_dev[31:16], hf_dev[47:32], base_conf[56:48], zero pad
	input  wire  [63:0] s_tdata,
	// results
	output logic        m_tvalid,
	input  wire         m_tready,
	// event_score[8:0], event_confidence[17:9], energy_score[26:18],
	// onset_score[35:27], spectral_score[44:36], zero pad
	output logic [47:0] m_tdata
);

	aes_pkg::aes_cfg_t   cfg_q;
	aes_pkg::aes_qstat_t qst;
	aes_pkg::aes_item_t  push_item;
	aes_pkg::aes_item_t  pop_item;
	logic                push;
	logic                pop;

	// Register file. Writes to an index outside the list fall on the
	// default arm and change nothing. Gains are 16 bit, weights and the
	// floor keep the low 9 bits of the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.energy_gain   <= aes_pkg::RST_ENERGY_GAIN;
			cfg_q.onset_gain    <= aes_pkg::RST_ONSET_GAIN;
			cfg_q.spectral_gain <= aes_pkg::RST_SPECTRAL_GAIN;
			cfg_q.energy_wt     <= aes_pkg::RST_ENERGY_WT;
			cfg_q.onset_wt      <= aes_pkg::RST_ONSET_WT;
			cfg_q.spectral_wt   <= aes_pkg::RST_SPECTRAL_WT;
			cfg_q.damping_floor <= aes_pkg::RST_DAMPING_FLOOR;
		end else if (cfg_we) begin
			case (cfg_index)
				aes_pkg::REG_ENERGY_GAIN:   cfg_q.energy_gain   <= cfg_data;
				aes_pkg::REG_ONSET_GAIN:    cfg_q.onset_gain    <= cfg_data;
				aes_pkg::REG_SPECTRAL_GAIN: cfg_q.spectral_gain <= cfg_data;
				aes_pkg::REG_ENERGY_WT:     cfg_q.energy_wt     <= cfg_data[8:0];
				aes_pkg::REG_ONSET_WT:      cfg_q.onset_wt      <= cfg_data[8:0];
				aes_pkg::REG_SPECTRAL_WT:   cfg_q.spectral_wt   <= cfg_data[8:0];
				aes_pkg::REG_DAMPING_FLOOR: cfg_q.damping_floor <= cfg_data[8:0];
				default:                    cfg_q <= cfg_q;
			endcase
		end
	end

	// Front end: takes a request whenever the queue has room, so it keeps
	// accepting while the back end is busy or a result waits on m_tready.
	aes_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.qst       (qst),
		.push      (push),
		.push_item (push_item)
	);

	aes_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.qst       (qst)
	);

	// Back end: one request at a time, result held in its output register.
	aes_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.qst      (qst),
		.q_item   (pop_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// ---- checks ------------------------------------------------------------
	logic [8:0] a_ev, a_agree, a_es, a_os, a_ss, a_mx, a_mn;

	always_comb begin
		a_ev    = m_tdata[8:0];
		a_agree = m_tdata[17:9];
		a_es    = m_tdata[26:18];
		a_os    = m_tdata[35:27];
		a_ss    = m_tdata[44:36];
		a_mx = a_es;
		a_mn = a_es;
		if (a_os > a_mx) a_mx = a_os;
		if (a_ss > a_mx) a_mx = a_ss;
		if (a_os < a_mn) a_mn = a_os;
		if (a_ss < a_mn) a_mn = a_ss;
	end

	// every score leaves saturated to 1.0
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (a_ev <= aes_pkg::SCORE_ONE) && (a_es <= aes_pkg::SCORE_ONE)
		          && (a_os <= aes_pkg::SCORE_ONE) && (a_ss <= aes_pkg::SCORE_ONE))
		else $error("score above full scale");

	// agreement matches the spread of the sub-scores sent with it
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> a_agree == aes_pkg::SCORE_ONE - (a_mx - a_mn))
		else $error("agreement inconsistent with sub-scores");

	// queue status is never full and empty at once
	assert property (@(posedge clk) disable iff (!arst_n)
		!(qst.full && qst.empty))
		else $error("queue status corrupt");

	// back end only pops an occupied queue and front only pushes with room
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop |-> !qst.empty) and (push |-> !qst.full))
		else $error("queue overrun or underrun");

endmodule

`default_nettype wire
